// ----- src/tseg_pkg.sv -----
// Shared types, constants and helper functions for the temperature display block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package tseg_pkg;

  // Input action codes
  localparam logic ACTION_READING = 1'b0;
  localparam logic ACTION_TICK    = 1'b1;

  // Display constants
  localparam logic [6:0] SIGN_MINUS     = 7'h40;
  localparam logic [7:0] DOT_BIT        = 8'h80;
  localparam logic [6:0] THRESHOLD_INIT = 7'd26;
  localparam logic [7:0] HUNDRED        = 8'd100;

  // Segment codes for one reading
  typedef struct packed {
    logic [6:0] sign_code;
    logic [7:0] hundreds_code;
    logic [7:0] tens_code;
    logic [7:0] units_code;
    logic [7:0] tenths_code;
    logic [7:0] hundredths_code;
  } digit_codes_t;

  // Two decimal digits of a value below one hundred
  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digit_pair_t;

  // Seven-segment code of one decimal digit
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    begin
      case (digit)
        4'd0:    code = 8'h3f;
        4'd1:    code = 8'h06;
        4'd2:    code = 8'h5b;
        4'd3:    code = 8'h4f;
        4'd4:    code = 8'h66;
        4'd5:    code = 8'h6d;
        4'd6:    code = 8'h7d;
        4'd7:    code = 8'h07;
        4'd8:    code = 8'h7f;
        4'd9:    code = 8'h6f;
        default: code = 8'h00;
      endcase
      return code;
    end
  endfunction

  // Split 0..99 into tens and units; x*205>>11 equals x/10 over this range
  function automatic digit_pair_t split_two(input logic [6:0] value);
    logic [14:0]  prod;
    logic [3:0]   tens;
    logic [6:0]   rest;
    digit_pair_t  pair;
    begin
      prod       = 15'(value) * 15'd205;
      tens       = prod[14:11];
      rest       = value - 7'(tens * 7'd10);
      pair.tens  = tens;
      pair.units = rest[3:0];
      return pair;
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/tseg_reading.sv -----
// Converts one raw sensor reading into segment codes, sign and whole degrees.
// Depends on tseg_pkg for the segment table and the digit split.
`default_nettype none

module tseg_reading (
  input  wire logic [11:0]           raw_temp,
  output tseg_pkg::digit_codes_t     codes,
  output logic [6:0]                 kept,
  output logic                       negative
);

  logic [12:0]           mag;
  logic [7:0]            whole;
  logic                  over_hundred;
  logic [6:0]            whole_low;
  logic [8:0]            frac_prod;
  logic [6:0]            frac;
  tseg_pkg::digit_pair_t whole_pair;
  tseg_pkg::digit_pair_t frac_pair;

  // Take the magnitude; the most negative reading gives 2048
  assign negative = raw_temp[11];
  assign mag      = negative ? (13'd0 - {raw_temp[11], raw_temp}) : {1'b0, raw_temp};

  // Hundredths = mag*25/4: whole degrees are mag/16, fraction from the low nibble
  assign whole        = mag[11:4];
  assign over_hundred = (whole >= tseg_pkg::HUNDRED);
  assign whole_low    = over_hundred ? 7'(whole - tseg_pkg::HUNDRED) : whole[6:0];
  assign frac_prod    = 9'(mag[3:0]) * 9'd25;
  assign frac         = frac_prod[8:2];

  assign whole_pair = tseg_pkg::split_two(whole_low);
  assign frac_pair  = tseg_pkg::split_two(frac);

  // Encode the digits
  always_comb begin
    codes.sign_code       = negative ? tseg_pkg::SIGN_MINUS : 7'd0;
    codes.hundreds_code   = tseg_pkg::seg_code({3'd0, over_hundred});
    codes.tens_code       = tseg_pkg::seg_code(whole_pair.tens);
    codes.units_code      = tseg_pkg::seg_code(whole_pair.units) | tseg_pkg::DOT_BIT;
    codes.tenths_code     = tseg_pkg::seg_code(frac_pair.tens);
    codes.hundredths_code = tseg_pkg::seg_code(frac_pair.units);
  end

  assign kept = whole_low;

endmodule

`default_nettype wire

// ----- src/temperature_to_segment_display.sv -----
// An accepted transaction passes the input register, then the result register, one per cycle
// unless the output stalls; the reading path is a single short combinational pass.
// An input register and the result register decouple the two channels.
// Reset (rst, synchronous): display codes blank, whole degrees 0, fan and beeper off,
// alarm threshold 26, both pipeline stages empty.
// Depends on tseg_pkg and tseg_reading.
`default_nettype none

module temperature_to_segment_display (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [6:0]         cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic signed [11:0] raw_temp,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [6:0]              sign_segments,
  output logic [7:0]              hundreds_segments,
  output logic [7:0]              tens_segments,
  output logic [7:0]              units_segments,
  output logic [7:0]              tenths_segments,
  output logic [7:0]              hundredths_segments,
  output logic                    fan_on,
  output logic                    beep_level,
  output logic [6:0]              whole_degrees
);

  logic                   alarm_threshold;
  logic [6:0]             threshold;
  logic                   stage_valid;
  logic                   stage_action;
  logic [11:0]            stage_raw;
  logic                   advance;
  logic                   accept;
  tseg_pkg::digit_codes_t digit_codes;
  tseg_pkg::digit_codes_t new_codes;
  logic [6:0]             kept_degrees;
  logic [6:0]             new_kept;
  logic                   is_negative;
  logic                   new_negative;
  logic                   fan;
  logic                   beeper;

  // Threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= tseg_pkg::THRESHOLD_INIT;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // Handshake: advance the held transaction when the result register is free or drains
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_action <= action;
      stage_raw    <= raw_temp;
    end
  end

  // Reading conversion
  tseg_reading u_reading (
    .raw_temp (stage_raw),
    .codes    (new_codes),
    .kept     (new_kept),
    .negative (new_negative)
  );

  // Alarm decision on a tick
  assign alarm_threshold = !is_negative && (kept_degrees >= threshold);

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      digit_codes  <= '0;
      kept_degrees <= 7'd0;
      is_negative  <= 1'b0;
      fan          <= 1'b0;
      beeper       <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (stage_action == tseg_pkg::ACTION_TICK) begin
          fan <= alarm_threshold;
          if (alarm_threshold) begin
            beeper <= !beeper;
          end
        end else begin
          digit_codes  <= new_codes;
          kept_degrees <= new_kept;
          is_negative  <= new_negative;
        end
      end
    end
  end

  // Drive the result fields
  assign sign_segments       = digit_codes.sign_code;
  assign hundreds_segments   = digit_codes.hundreds_code;
  assign tens_segments       = digit_codes.tens_code;
  assign units_segments      = digit_codes.units_code;
  assign tenths_segments     = digit_codes.tenths_code;
  assign hundredths_segments = digit_codes.hundredths_code;
  assign fan_on              = fan;
  assign beep_level          = beeper;
  assign whole_degrees       = kept_degrees;

  // Fan turns on only after an advanced tick
  assert property (@(posedge clk) disable iff (rst)
    $rose(fan) |-> $past(advance && (stage_action == tseg_pkg::ACTION_TICK)))
    else $error("fan rose without a tick");

  // Beeper toggles only together with an alarming tick
  assert property (@(posedge clk) disable iff (rst)
    !$stable(beeper) |-> fan && $past(advance && (stage_action == tseg_pkg::ACTION_TICK)))
    else $error("beeper changed without an alarming tick");

  // A negative reading never alarms
  assert property (@(posedge clk) disable iff (rst)
    $rose(fan) |-> !is_negative)
    else $error("alarm raised on a negative reading");

  // Kept degrees stay below one hundred
  assert property (@(posedge clk) disable iff (rst)
    kept_degrees <= 7'd99)
    else $error("kept degrees out of range");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for temperature_to_segment_display: directed and random readings,
// ticks and threshold writes, checked against an in-bench model of the display and alarm.
// Depends on tseg_pkg and the RTL of the block; reads no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASES = 6;

  // Seven-segment font for digits 0..9
  localparam logic [7:0] SEG_FONT [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                          8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};

  typedef struct packed {
    tseg_pkg::digit_codes_t codes;
    logic                   fan;
    logic                   beep;
    logic [6:0]             degrees;
  } display_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic action;
  logic signed [11:0] raw_temp;
  logic out_valid;
  logic out_stall;
  logic [6:0] sign_segments;
  logic [7:0] hundreds_segments;
  logic [7:0] tens_segments;
  logic [7:0] units_segments;
  logic [7:0] tenths_segments;
  logic [7:0] hundredths_segments;
  logic fan_on;
  logic beep_level;
  logic [6:0] whole_degrees;

  // Display and alarm state of the model
  tseg_pkg::digit_codes_t shown_codes;
  logic [6:0] shown_degrees;
  logic shown_negative;
  logic beep_state;
  logic fan_state;
  logic [6:0] alarm_limit;

  display_t pending_displays[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  temperature_to_segment_display i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .action              (action),
    .raw_temp            (raw_temp),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .sign_segments       (sign_segments),
    .hundreds_segments   (hundreds_segments),
    .tens_segments       (tens_segments),
    .units_segments      (units_segments),
    .tenths_segments     (tenths_segments),
    .hundredths_segments (hundredths_segments),
    .fan_on              (fan_on),
    .beep_level          (beep_level),
    .whole_degrees       (whole_degrees)
  );

  always #6 clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_displays.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Apply one transaction to the model and return the display it leaves
  task automatic advance_display(input logic act, input logic [11:0] raw, output display_t res);
    logic [12:0] mag;
    int scaled;
    if (act == tseg_pkg::ACTION_TICK) begin
      if (!shown_negative && shown_degrees >= alarm_limit) begin
        beep_state = ~beep_state;
        fan_state = 1'b1;
      end else begin
        fan_state = 1'b0;
      end
    end else begin
      shown_negative = raw[11];
      mag = raw[11] ? 13'd4096 - {1'b0, raw} : {1'b0, raw};
      scaled = (int'(mag) * 25) >> 2;
      shown_codes.sign_code = raw[11] ? tseg_pkg::SIGN_MINUS : 7'd0;
      shown_codes.hundreds_code = SEG_FONT[(scaled / 10000) % 10];
      shown_codes.tens_code = SEG_FONT[(scaled % 10000) / 1000];
      shown_codes.units_code = SEG_FONT[(scaled % 1000) / 100] | tseg_pkg::DOT_BIT;
      shown_codes.tenths_code = SEG_FONT[(scaled % 100) / 10];
      shown_codes.hundredths_code = SEG_FONT[scaled % 10];
      shown_degrees = 7'((scaled / 100) % 100);
    end
    res.codes = shown_codes;
    res.fan = fan_state;
    res.beep = beep_state;
    res.degrees = shown_degrees;
  endtask

  // Send one transaction, inserting burst gaps, and record its expected display
  task automatic send_item(input logic act, input logic [11:0] raw);
    int gap;
    display_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    raw_temp <= raw;
    do @(posedge clk); while (in_stall);
    advance_display(act, raw, res);
    pending_displays.push_back(res);
  endtask

  // Drop valid and let every outstanding transaction drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [6:0] thr);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alarm_limit = thr;
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Check each accepted result and drive the receiver's stall pattern
  always @(posedge clk) begin : result_check
    display_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_displays.size() == 0) begin
        $display("%0t: result with no transaction outstanding", $time);
        errors++;
      end else begin
        want = pending_displays.pop_front();
        report_field("sign_segments", want.codes.sign_code, sign_segments);
        report_field("hundreds_segments", want.codes.hundreds_code, hundreds_segments);
        report_field("tens_segments", want.codes.tens_code, tens_segments);
        report_field("units_segments", want.codes.units_code, units_segments);
        report_field("tenths_segments", want.codes.tenths_code, tenths_segments);
        report_field("hundredths_segments", want.codes.hundredths_code,
                     hundredths_segments);
        report_field("fan_on", want.fan, fan_on);
        report_field("beep_level", want.beep, beep_level);
        report_field("whole_degrees", want.degrees, whole_degrees);
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycles % 3 == 0);
    endcase
  end

  // Tick before any reading: blank display, no alarm
  task automatic test_blank_display();
    send_item(tseg_pkg::ACTION_TICK, 12'd0);
  endtask

  // Zero, smallest steps, largest positive, most negative and hundred-degree wrap
  task automatic test_reading_extremes();
    send_item(tseg_pkg::ACTION_READING, 12'd0);
    send_item(tseg_pkg::ACTION_READING, 12'd1);
    send_item(tseg_pkg::ACTION_READING, 12'h7ff);
    send_item(tseg_pkg::ACTION_READING, 12'hfff);
    send_item(tseg_pkg::ACTION_READING, 12'h800);
    send_item(tseg_pkg::ACTION_READING, 12'd16);
    send_item(tseg_pkg::ACTION_READING, 12'd1600);
  endtask

  // Alarm at the default threshold, beeper toggling, negative reading never alarming
  task automatic test_alarm_edge();
    send_item(tseg_pkg::ACTION_READING, 12'd415);
    send_item(tseg_pkg::ACTION_TICK, 12'hfff);
    send_item(tseg_pkg::ACTION_READING, 12'd416);
    send_item(tseg_pkg::ACTION_TICK, 12'd0);
    send_item(tseg_pkg::ACTION_TICK, 12'd0);
    send_item(tseg_pkg::ACTION_READING, -12'sd416);
    send_item(tseg_pkg::ACTION_TICK, 12'd0);
  endtask

  // Threshold at zero, at 99 and above 99
  task automatic test_threshold_extremes();
    write_threshold(7'd0);
    send_item(tseg_pkg::ACTION_TICK, 12'd0);
    send_item(tseg_pkg::ACTION_READING, 12'd0);
    send_item(tseg_pkg::ACTION_TICK, 12'd0);
    write_threshold(7'd99);
    send_item(tseg_pkg::ACTION_READING, 12'd1599);
    send_item(tseg_pkg::ACTION_TICK, 12'd0);
    send_item(tseg_pkg::ACTION_READING, 12'd1600);
    send_item(tseg_pkg::ACTION_TICK, 12'd0);
    write_threshold(7'd127);
    send_item(tseg_pkg::ACTION_READING, 12'd1599);
    send_item(tseg_pkg::ACTION_TICK, 12'd0);
  endtask

  // Random readings and ticks over several thresholds, biased around the threshold
  task automatic test_random_traffic();
    logic [6:0] limits [PHASES];
    int pick;
    int near_value;
    limits = '{7'($urandom_range(0, 99)), 7'd0, 7'd99, 7'd127, 7'($urandom_range(0, 127)),
               tseg_pkg::THRESHOLD_INIT};
    for (int p = 0; p < PHASES; p++) begin
      write_threshold(limits[p]);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        pick = $urandom_range(0, 99);
        near_value = int'(alarm_limit) * 16 + $urandom_range(0, 31) - 16;
        if (pick < 40)
          send_item(tseg_pkg::ACTION_TICK, 12'($urandom));
        else if (pick < 70)
          send_item(tseg_pkg::ACTION_READING, 12'($urandom));
        else if (pick < 88)
          send_item(tseg_pkg::ACTION_READING, 12'(near_value));
        else if (pick < 94 && near_value + 1600 <= 2047)
          send_item(tseg_pkg::ACTION_READING, 12'(near_value + 1600));
        else
          send_item(tseg_pkg::ACTION_READING, 12'(-$urandom_range(1, 2048)));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= 7'd0;
    in_valid <= 1'b0;
    action <= tseg_pkg::ACTION_READING;
    raw_temp <= 12'd0;
    out_stall <= 1'b0;
    shown_codes = '0;
    shown_degrees = 7'd0;
    shown_negative = 1'b0;
    beep_state = 1'b0;
    fan_state = 1'b0;
    alarm_limit = tseg_pkg::THRESHOLD_INIT;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_blank_display();
    test_reading_extremes();
    test_alarm_edge();
    test_threshold_extremes();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
